FILE: src/dense_to_coo_compactor_defines.svh
// Assertion macros shared by the dense-to-COO compactor RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DENSE_TO_COO_COMPACTOR_DEFINES_SVH
`define DENSE_TO_COO_COMPACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/dtc_pkg.sv
// Package for the dense-to-COO compactor: widths, register indexes, result type.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dtc_pkg;

  localparam int HW_DIMS             = 4;
  localparam int VALUE_BITS          = 32;
  localparam int COUNT_BITS          = 32;
  localparam int SIZE_BITS           = 16;
  localparam int OUT_COORD_BITS      = 16;
  localparam int DIM_COUNT_BITS      = 3;
  localparam int CFG_DATA_BITS       = 16;
  localparam int CFG_INDEX_BITS      = 3;
  localparam int QUEUE_DEPTH         = 2;
  localparam int MAX_DIMS_DEFAULT    = 4;
  localparam int COORD_BITS_DEFAULT  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DIMENSION_COUNT = 3'd0,
    REG_SIZE_DIM0       = 3'd1,
    REG_SIZE_DIM1       = 3'd2,
    REG_SIZE_DIM2       = 3'd3,
    REG_SIZE_DIM3       = 3'd4
  } dtc_reg_t;

  typedef struct packed {
    logic                                     carries_entry;
    logic signed [VALUE_BITS-1:0]             entry_value;
    logic [HW_DIMS-1:0][OUT_COORD_BITS-1:0]   coord;
    logic [COUNT_BITS-1:0]                    entry_position;
    logic                                     tensor_done;
    logic [COUNT_BITS-1:0]                    total_nonzero;
  } dtc_result_t;

endpackage

`default_nettype wire

FILE: src/dtc_front.sv
// Front end of the compactor: configuration registers, odometer, nonzero count, classification.
// Depends on dtc_pkg and the assertion macros in dense_to_coo_compactor_defines.svh.
`default_nettype none
`include "dense_to_coo_compactor_defines.svh"

module dtc_front
  import dtc_pkg::*;
#(
  parameter int MAX_DIMS   = MAX_DIMS_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_BITS-1:0]  element_value,
  input  logic                          q_full,
  output logic                          push,
  output dtc_result_t                   result
);

  localparam int USED_DIMS = (MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS;
  localparam int CMP_W     = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;
  localparam logic [CMP_W-1:0] EXT_MAX = CMP_W'(1) << COORD_BITS;

  logic [DIM_COUNT_BITS-1:0]              dim_count;
  logic [HW_DIMS-1:0][SIZE_BITS-1:0]      size;
  logic [USED_DIMS-1:0][COORD_BITS-1:0]   counter;
  logic [USED_DIMS-1:0][COORD_BITS-1:0]   counter_next;
  logic [COUNT_BITS-1:0]                  nonzero_count;
  logic [COUNT_BITS-1:0]                  nonzero_count_next;

  logic [DIM_COUNT_BITS-1:0]              n_eff;
  logic [USED_DIMS-1:0]                   in_use;
  logic [USED_DIMS-1:0][CMP_W-1:0]        extent;
  logic [USED_DIMS-1:0]                   at_end;
  logic                                   last;
  logic                                   nonzero;
  logic                                   carry;
  logic                                   accept;
  logic [COUNT_BITS-1:0]                  total;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign nonzero  = (element_value != '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= DIM_COUNT_BITS'(1);
      for (int i = 0; i < HW_DIMS; i++) size[i] <= SIZE_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIMENSION_COUNT: dim_count <= cfg_data[DIM_COUNT_BITS-1:0];
        REG_SIZE_DIM0:       size[0]   <= cfg_data[SIZE_BITS-1:0];
        REG_SIZE_DIM1:       size[1]   <= cfg_data[SIZE_BITS-1:0];
        REG_SIZE_DIM2:       size[2]   <= cfg_data[SIZE_BITS-1:0];
        REG_SIZE_DIM3:       size[3]   <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // classify the element and step the odometer
  always_comb begin
    n_eff = dim_count;
    if (dim_count == '0) begin
      n_eff = DIM_COUNT_BITS'(1);
    end else if (dim_count > DIM_COUNT_BITS'(USED_DIMS)) begin
      n_eff = DIM_COUNT_BITS'(USED_DIMS);
    end

    for (int d = 0; d < USED_DIMS; d++) begin
      in_use[d] = (DIM_COUNT_BITS'(d) < n_eff);
      extent[d] = CMP_W'(size[d]);
      if (size[d] == '0) extent[d] = CMP_W'(1);
      if (extent[d] > EXT_MAX) extent[d] = EXT_MAX;
      // a digit at or past its extent minus one counts as being at its end
      at_end[d] = ((CMP_W'(counter[d]) + CMP_W'(1)) >= extent[d]);
    end

    last = &(at_end | ~in_use);

    counter_next = counter;
    carry = 1'b1;
    for (int k = USED_DIMS - 1; k >= 0; k--) begin
      if (in_use[k] && carry) begin
        if (at_end[k]) counter_next[k] = '0;
        else           counter_next[k] = counter[k] + COORD_BITS'(1);
      end
      carry = carry & (at_end[k] | ~in_use[k]);
    end
    if (last) counter_next = '0;

    total = nonzero_count;
    if (nonzero && (nonzero_count != '1)) total = nonzero_count + COUNT_BITS'(1);
    nonzero_count_next = last ? '0 : total;

    result = '0;
    result.carries_entry = nonzero;
    result.tensor_done   = last;
    result.total_nonzero = total;
    if (nonzero) begin
      result.entry_value    = element_value;
      result.entry_position = nonzero_count;
      for (int j = 0; j < USED_DIMS; j++) begin
        if (in_use[j]) result.coord[j] = OUT_COORD_BITS'(counter[j]);
      end
    end

    push = accept && (nonzero || last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter       <= '0;
      nonzero_count <= '0;
    end else if (accept) begin
      counter       <= counter_next;
      nonzero_count <= nonzero_count_next;
    end
  end

  `DTC_ASSERT_NEXT(a_last_clears, clk, rst, accept && last, (nonzero_count == '0) && (counter == '0), "odometer or count not cleared after final element")
  `DTC_ASSERT_NEXT(a_count_step, clk, rst, accept && !last && nonzero && (nonzero_count != '1), nonzero_count == $past(nonzero_count) + COUNT_BITS'(1), "nonzero count did not advance")
  `DTC_ASSERT_NEXT(a_count_hold, clk, rst, accept && !last && !nonzero, nonzero_count == $past(nonzero_count), "nonzero count moved on a zero element")

endmodule

`default_nettype wire

FILE: src/dtc_queue.sv
// Short result queue between the front end and the output stage of the compactor.
// Depends on dtc_pkg and the assertion macros in dense_to_coo_compactor_defines.svh.
`default_nettype none
`include "dense_to_coo_compactor_defines.svh"

module dtc_queue
  import dtc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dtc_result_t  push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output dtc_result_t  head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dtc_result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `DTC_ASSERT_NOW(a_no_overflow, clk, rst, push, !full, "push into a full queue")
  `DTC_ASSERT_NOW(a_no_underflow, clk, rst, pop, head_valid, "pop from an empty queue")
  `DTC_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

FILE: src/dtc_back.sv
// Output stage of the compactor: registers the queue head and presents it to the receiver.
// Depends on dtc_pkg.
`default_nettype none

module dtc_back
  import dtc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  dtc_result_t  head_data,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output dtc_result_t  out_data
);

  // refill whenever the register is empty or its content is being taken
  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= head_data;
  end

endmodule

`default_nettype wire

FILE: src/dense_to_coo_compactor.sv
// Top level of the dense-to-COO compactor: front end, result queue, output stage.
// Depends on dtc_pkg, dtc_front, dtc_queue and dtc_back.
//
// Usage:
//   Dense elements arrive on the input channel (in_valid / in_stall / element_value) in
//   row-major order, one transfer per element. A nonzero element yields one result with
//   its value, coordinates and list position; the final element of the tensor always
//   yields a result with tensor_done set and the total nonzero count. Other zeros yield
//   nothing. Results leave on the output channel (out_valid / out_stall and the fields).
//   Throughput: one element per cycle while in_stall is low, set by the combinational
//   odometer step in the front end. An accepted result is written into the queue and
//   then into the output register before the receiver can take it.
//   The configuration port (cfg_we / cfg_index / cfg_data) writes the dimension count
//   and extents; write only while the block is idle. Writes never touch the odometer.
//   Reset: synchronous on rst; dimension count and extents return to 1, the odometer and
//   nonzero count to zero, queue and output register empty. No clearing pass.
//   Receiver stall: the output register holds its result; the two-entry queue absorbs
//   further results, and in_stall rises once it is full.
`default_nettype none

module dense_to_coo_compactor
  import dtc_pkg::*;
#(
  parameter int MAX_DIMS   = MAX_DIMS_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [VALUE_BITS-1:0]      element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              carries_entry,
  output logic signed [VALUE_BITS-1:0]      entry_value,
  output logic [OUT_COORD_BITS-1:0]         coord0,
  output logic [OUT_COORD_BITS-1:0]         coord1,
  output logic [OUT_COORD_BITS-1:0]         coord2,
  output logic [OUT_COORD_BITS-1:0]         coord3,
  output logic [COUNT_BITS-1:0]             entry_position,
  output logic                              tensor_done,
  output logic [COUNT_BITS-1:0]             total_nonzero
);

  logic         q_full;
  logic         push;
  dtc_result_t  push_data;
  logic         pop;
  logic         head_valid;
  dtc_result_t  head_data;
  dtc_result_t  out_data;

  // classify each element and advance the odometer
  dtc_front #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .q_full        (q_full),
    .push          (push),
    .result        (push_data)
  );

  // decouple the front end from receiver stalls
  dtc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // hold the result until the receiver takes it
  dtc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign carries_entry  = out_data.carries_entry;
  assign entry_value    = out_data.entry_value;
  assign coord0         = out_data.coord[0];
  assign coord1         = out_data.coord[1];
  assign coord2         = out_data.coord[2];
  assign coord3         = out_data.coord[3];
  assign entry_position = out_data.entry_position;
  assign tensor_done    = out_data.tensor_done;
  assign total_nonzero  = out_data.total_nonzero;

endmodule

`default_nettype wire
